// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

// ----- rtl/aprs_pcp_pkg.sv -----
// Package with the word types, character codes and helper functions of the path parser.
`timescale 1ns / 1ps
`default_nettype none

package aprs_pcp_pkg;

	localparam int MAX_CHARS_DEF = 16;

	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [4:0] SSID_MAX = 5'd15;
	localparam logic [4:0] SSID_SAT = 5'd16;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_DONE   = 2'd3
	} ssid_phase_t;

	typedef enum logic [1:0] {
		TF_EMPTY = 2'd0,
		TF_ZERO  = 2'd1,
		TF_ZERO2 = 2'd2,
		TF_OTHER = 2'd3
	} text_form_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
		logic       special;
	} item_t;

	typedef struct packed {
		logic       valid_res;
		logic       digipeat;
		logic [3:0] ssid;
		logic       wide;
		logic [1:0] wide_total;
		logic [1:0] wide_remain;
		logic [4:0] callsign_length;
	} verdict_t;

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alnum_up(input logic [7:0] c);
		return is_digit(c) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic [7:0] wide_char(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0: r = 8'h57;
			2'd1: r = 8'h49;
			2'd2: r = 8'h44;
			default: r = 8'h45;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/aprs_path_callsign_parser.sv -----
// Top level of the path element parser: one character word in, one verdict word per element.
// The verdict of a closing character passes from the input register through the result register to the output.
// Throughput: one character word per cycle; only the result register stalls the input.
// The parser state updates in a single pass from the input register to the result register.
// Reset (arst_n low) empties both registers and returns the parser to an empty element.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module aprs_path_callsign_parser #(
	parameter int MAX_CHARS = aprs_pcp_pkg::MAX_CHARS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output logic                        item_stall,
	input  wire aprs_pcp_pkg::item_t    item,
	output logic                        verdict_valid,
	input  wire logic                   verdict_stall,
	output aprs_pcp_pkg::verdict_t      verdict
);

	logic                   out_free;
	logic                   valid_s1;
	aprs_pcp_pkg::item_t    item_s1;
	logic                   step;
	aprs_pcp_pkg::verdict_t verdict_d;

	aprs_pcp_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.out_free   (out_free),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.step       (step)
	);

	aprs_pcp_core #(
		.MAX_CHARS (MAX_CHARS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item_s1   (item_s1),
		.verdict_d (verdict_d)
	);

	aprs_pcp_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (step && item_s1.last),
		.verdict_d     (verdict_d),
		.out_free      (out_free),
		.verdict_valid (verdict_valid),
		.verdict_stall (verdict_stall),
		.verdict       (verdict)
	);

	`ASSERT_CLK(a_mid_char_no_stall, (valid_s1 && !item_s1.last) |-> !item_stall, "mid-element character stalled the input")
	`ASSERT_CLK(a_invalid_zero, (verdict_valid && !verdict.valid_res) |-> (verdict == '0), "invalid verdict carries nonzero fields")
	`ASSERT_CLK(a_wide_range, (verdict_valid && verdict.wide) |-> (verdict.wide_total != 2'd0 && verdict.wide_remain <= verdict.wide_total), "wide alias hop counts out of range")
	`ASSERT_NEVER(a_digi_valid, verdict_valid && verdict.digipeat && !verdict.valid_res, "digipeat flag on invalid verdict")

endmodule

`default_nettype wire

// ----- rtl/aprs_pcp_in_reg.sv -----
// Input register that holds one accepted character word until the parser takes it.
`timescale 1ns / 1ps
`default_nettype none

module aprs_pcp_in_reg (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire aprs_pcp_pkg::item_t  item,
	input  wire logic                 out_free,
	output logic                      valid_s1,
	output aprs_pcp_pkg::item_t       item_s1,
	output logic                      step
);

	logic load;

	// A closing character moves on only when the result register can take its verdict.
	assign step       = valid_s1 && (!item_s1.last || out_free);
	assign item_stall = valid_s1 && !step;
	assign load       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= load || (valid_s1 && !step);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/aprs_pcp_core.sv -----
// Parser state for one path element and the combinational verdict logic.
`timescale 1ns / 1ps
`default_nettype none

module aprs_pcp_core #(
	parameter int MAX_CHARS = aprs_pcp_pkg::MAX_CHARS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire aprs_pcp_pkg::item_t item_s1,
	output aprs_pcp_pkg::verdict_t   verdict_d
);

	localparam int CCW = $clog2(MAX_CHARS + 1);
	localparam int CLW = $clog2(MAX_CHARS + 2);

	logic [CCW-1:0]            cc_q, cc_t;
	logic                      ovf_q, ovf_t;
	logic                      dash_q, dash_t;
	logic [CLW-1:0]            clen_q, clen_t;
	logic                      alnum_q, alnum_t;
	logic                      wp_q, wp_t;
	logic [3:0]                fifth_q, fifth_t;
	aprs_pcp_pkg::ssid_phase_t phase_q, phase_t;
	logic [4:0]                sval_q, sval_t;
	aprs_pcp_pkg::text_form_t  form_q, form_t;

	logic [7:0] c;
	logic       take;
	logic       dig;
	logic       match;
	logic [7:0] prod;
	logic [4:0] acc;
	logic [3:0] ssid_v;
	logic       is_wide;
	logic       bad;

	assign c    = aprs_pcp_pkg::to_upper(item_s1.char_code);
	assign dig  = item_s1.last && !item_s1.special && c == aprs_pcp_pkg::CH_STAR;
	assign take = !item_s1.last || (!item_s1.special && c != aprs_pcp_pkg::CH_STAR);
	assign prod = 8'(sval_q) * 8'd10 + {4'b0, c[3:0]};
	assign acc  = (prod > 8'(aprs_pcp_pkg::SSID_SAT)) ? aprs_pcp_pkg::SSID_SAT : prod[4:0];
	assign match = c == aprs_pcp_pkg::wide_char(clen_q[1:0]);

	always_comb begin
		cc_t    = cc_q;
		ovf_t   = ovf_q;
		dash_t  = dash_q;
		clen_t  = clen_q;
		alnum_t = alnum_q;
		wp_t    = wp_q;
		fifth_t = fifth_q;
		phase_t = phase_q;
		sval_t  = sval_q;
		form_t  = form_q;
		if (cc_q >= CCW'(MAX_CHARS)) begin
			ovf_t = 1'b1;
		end else begin
			cc_t = cc_q + CCW'(1);
		end
		if (take) begin
			if (dash_q) begin
				if (form_q == aprs_pcp_pkg::TF_EMPTY && c == aprs_pcp_pkg::CH_ZERO) begin
					form_t = aprs_pcp_pkg::TF_ZERO;
				end else if (form_q == aprs_pcp_pkg::TF_ZERO && c == aprs_pcp_pkg::CH_ZERO) begin
					form_t = aprs_pcp_pkg::TF_ZERO2;
				end else begin
					form_t = aprs_pcp_pkg::TF_OTHER;
				end
				case (phase_q)
					aprs_pcp_pkg::PH_SKIP: begin
						if (aprs_pcp_pkg::is_space(c)) begin
							phase_t = aprs_pcp_pkg::PH_SKIP;
						end else if (c == aprs_pcp_pkg::CH_PLUS) begin
							phase_t = aprs_pcp_pkg::PH_DIGITS;
						end else if (c == aprs_pcp_pkg::CH_DASH) begin
							sval_t  = aprs_pcp_pkg::SSID_SAT;
							phase_t = aprs_pcp_pkg::PH_DONE;
						end else if (!aprs_pcp_pkg::is_digit(c)) begin
							phase_t = aprs_pcp_pkg::PH_DONE;
						end else begin
							phase_t = aprs_pcp_pkg::PH_DIGITS;
							sval_t  = acc;
						end
					end
					aprs_pcp_pkg::PH_DIGITS: begin
						if (aprs_pcp_pkg::is_digit(c)) begin
							sval_t = acc;
						end else begin
							phase_t = aprs_pcp_pkg::PH_DONE;
						end
					end
					default: begin
						phase_t = phase_q;
					end
				endcase
			end else if (c == aprs_pcp_pkg::CH_DASH) begin
				dash_t = 1'b1;
			end else begin
				if (!aprs_pcp_pkg::is_alnum_up(c)) begin
					alnum_t = 1'b0;
				end
				if (clen_q < CLW'(4)) begin
					wp_t = (clen_q == '0) ? match : (wp_q && match);
				end else if (clen_q == CLW'(4)) begin
					fifth_t = aprs_pcp_pkg::is_digit(c) ? c[3:0] : 4'd0;
				end
				if (clen_q <= CLW'(MAX_CHARS)) begin
					clen_t = clen_q + CLW'(1);
				end
			end
		end
	end

	assign ssid_v  = dash_t ? sval_t[3:0] : 4'd0;
	assign is_wide = (clen_t == CLW'(5)) && wp_t;

	always_comb begin
		bad = ovf_t || !alnum_t;
		if (!dash_t) begin
			if (cc_t == CCW'(1) && dig) begin
				bad = 1'b1;
			end
		end else begin
			if (sval_t > aprs_pcp_pkg::SSID_MAX) begin
				bad = 1'b1;
			end
			if (sval_t == 5'd0 && form_t != aprs_pcp_pkg::TF_ZERO
					&& form_t != aprs_pcp_pkg::TF_ZERO2) begin
				bad = 1'b1;
			end
		end
		if (is_wide && (fifth_t < 4'd1 || fifth_t > 4'd2 || fifth_t < ssid_v)) begin
			bad = 1'b1;
		end
	end

	always_comb begin
		verdict_d = '0;
		if (item_s1.special) begin
			if (!ovf_t) begin
				verdict_d.valid_res       = 1'b1;
				verdict_d.callsign_length = 5'(cc_t);
			end
		end else if (!bad) begin
			verdict_d.valid_res       = 1'b1;
			verdict_d.digipeat        = dig;
			verdict_d.ssid            = ssid_v;
			verdict_d.wide            = is_wide;
			verdict_d.wide_total      = is_wide ? fifth_t[1:0] : 2'd0;
			verdict_d.wide_remain     = is_wide ? ssid_v[1:0] : 2'd0;
			verdict_d.callsign_length = 5'(clen_t);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q    <= '0;
			ovf_q   <= 1'b0;
			dash_q  <= 1'b0;
			clen_q  <= '0;
			alnum_q <= 1'b1;
			wp_q    <= 1'b0;
			fifth_q <= '0;
			phase_q <= aprs_pcp_pkg::PH_SKIP;
			sval_q  <= '0;
			form_q  <= aprs_pcp_pkg::TF_EMPTY;
		end else if (step) begin
			if (item_s1.last) begin
				cc_q    <= '0;
				ovf_q   <= 1'b0;
				dash_q  <= 1'b0;
				clen_q  <= '0;
				alnum_q <= 1'b1;
				wp_q    <= 1'b0;
				fifth_q <= '0;
				phase_q <= aprs_pcp_pkg::PH_SKIP;
				sval_q  <= '0;
				form_q  <= aprs_pcp_pkg::TF_EMPTY;
			end else begin
				cc_q    <= cc_t;
				ovf_q   <= ovf_t;
				dash_q  <= dash_t;
				clen_q  <= clen_t;
				alnum_q <= alnum_t;
				wp_q    <= wp_t;
				fifth_q <= fifth_t;
				phase_q <= phase_t;
				sval_q  <= sval_t;
				form_q  <= form_t;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/aprs_pcp_out_reg.sv -----
// Result register that holds one verdict word until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none

module aprs_pcp_out_reg (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load,
	input  wire aprs_pcp_pkg::verdict_t verdict_d,
	output logic                        out_free,
	output logic                        verdict_valid,
	input  wire logic                   verdict_stall,
	output aprs_pcp_pkg::verdict_t      verdict
);

	assign out_free = !verdict_valid || !verdict_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid <= 1'b0;
		end else begin
			verdict_valid <= load || (verdict_valid && verdict_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			verdict <= verdict_d;
		end
	end

endmodule

`default_nettype wire
